// ===== hdl/btree_node_sector_map_unit_assert.svh =====
// Assertion macros for the B-tree node sector map unit.
// Included by the RTL files that check their own logic; no other dependencies.
`ifndef BTREE_NODE_SECTOR_MAP_UNIT_ASSERT_SVH
`define BTREE_NODE_SECTOR_MAP_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// ante holds now -> cons holds in the same cycle
`define BNSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante holds now -> cons holds in the next cycle
`define BNSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define BNSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define BNSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hdl/bnsm_pkg.sv =====
// Shared types and constants of the B-tree node sector map unit.
// No dependencies; imported by the interfaces and the top level.
package bnsm_pkg;

	// extent table geometry
	localparam int EXTENT_SLOTS = 8;
	localparam int IDX_W        = (EXTENT_SLOTS > 1) ? $clog2(EXTENT_SLOTS) : 1;
	localparam int SLOT_W       = 3;
	localparam int SLOT_EXT_W   = 5;

	// field widths
	localparam int NODE_SIZE_W = 16;
	localparam int BLOCK_W     = 21;
	localparam int SECTOR_W    = 13;
	localparam int WORD_W      = 32;
	localparam int SECT_OUT_W  = 64;
	localparam int CNT_W       = 7;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_SIZE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_SIZE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SECTOR = 2'd3;

	// input modes and result status
	localparam logic MODE_WRITE     = 1'b0;
	localparam logic MODE_TRANSLATE = 1'b1;
	localparam logic STATUS_MAPPED  = 1'b0;
	localparam logic STATUS_UNMAPPED = 1'b1;

	localparam logic [CNT_W-1:0] CNT_MAX = 7'h7F;

	typedef struct packed {
		logic              mode;
		logic [SLOT_W-1:0] slot;
		logic [WORD_W-1:0] extent_first_block;
		logic [WORD_W-1:0] extent_length;
		logic [WORD_W-1:0] node_idx;
	} req_t;

	typedef struct packed {
		logic [SECT_OUT_W-1:0] node_sector;
		logic [CNT_W-1:0]      sector_count;
		logic                  status;
	} rsp_t;

endpackage

// ===== hdl/bnsm_req_if.sv =====
// Request channel of the B-tree node sector map unit: valid, ready, payload.
// Depends on bnsm_pkg.
interface bnsm_req_if import bnsm_pkg::*; ();
	logic valid;
	logic ready;
	req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/bnsm_rsp_if.sv =====
// Result channel of the B-tree node sector map unit: valid, ready, payload.
// Depends on bnsm_pkg.
interface bnsm_rsp_if import bnsm_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/btree_node_sector_map_unit.sv =====
// B-tree node sector map unit: node number to first device sector and sector count.
// Depends on bnsm_pkg, bnsm_req_if, bnsm_rsp_if and the assertion macro header.
// Slot writes: one per cycle while the unit is idle. Translate: one shared restoring divider runs 48+21+21+16
// steps, then the walk visits one slot a cycle; the result loads once the result channel is free, and
// only then is a new request taken (a zero block or sector size goes straight to an error result).
// Asynchronous reset: configuration registers to defaults, extent table cleared, channels idle.
`include "btree_node_sector_map_unit_assert.svh"

module btree_node_sector_map_unit import bnsm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	bnsm_req_if.sink              req,
	bnsm_rsp_if.source            rsp
);

	localparam int DIV_W  = 48;
	localparam int STEP_W = 6;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_MUL     = 4'd1;
	localparam logic [3:0] ST_DIV_BLK = 4'd2;
	localparam logic [3:0] ST_DIV_PER = 4'd3;
	localparam logic [3:0] ST_DIV_OFF = 4'd4;
	localparam logic [3:0] ST_DIV_CNT = 4'd5;
	localparam logic [3:0] ST_WALK    = 4'd6;
	localparam logic [3:0] ST_MUL2    = 4'd7;
	localparam logic [3:0] ST_SUM     = 4'd8;
	localparam logic [3:0] ST_DONE    = 4'd9;

	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(EXTENT_SLOTS - 1);

	// configuration registers
	logic [NODE_SIZE_W-1:0] node_size_q;
	logic [BLOCK_W-1:0]     block_size_q;
	logic [SECTOR_W-1:0]    sector_size_q;
	logic [WORD_W-1:0]      first_sector_q;

	// extent table
	logic [WORD_W-1:0] ext_start_q [EXTENT_SLOTS];
	logic [WORD_W-1:0] ext_count_q [EXTENT_SLOTS];

	// sequencer and work registers
	logic [3:0]             state_q;
	logic                   err_q;
	logic [WORD_W-1:0]      node_q;
	logic [WORD_W-1:0]      remaining_q;
	logic [BLOCK_W-1:0]     inblk_q;
	logic [BLOCK_W-1:0]     perblk_q;
	logic [WORD_W:0]        base_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [IDX_W-1:0]       walk_k_q;
	logic [WORD_W-1:0]      blk_q;
	logic [WORD_W+BLOCK_W-1:0] prod2_q;
	logic [SECT_OUT_W-1:0]  sector_q;

	// shared divider
	logic [DIV_W-1:0]   div_num_q;
	logic [BLOCK_W-1:0] div_rem_q;
	logic [BLOCK_W-1:0] div_den_q;
	logic [STEP_W-1:0]  div_step_q;

	// output register
	logic                  rsp_valid_q;
	logic [SECT_OUT_W-1:0] rsp_sector_q;
	logic [CNT_W-1:0]      rsp_cnt_q;
	logic                  rsp_status_q;

	logic [SLOT_EXT_W-1:0] slot_ext;
	logic                  req_fire;
	logic                  rsp_fire;

	logic [BLOCK_W:0]   div_shift;
	logic [BLOCK_W:0]   div_diff;
	logic               div_ge;
	logic [BLOCK_W-1:0] div_rem_nx;
	logic [DIV_W-1:0]   div_num_nx;
	logic               div_last;
	logic [NODE_SIZE_W-1:0] cnt_quot;
	logic [CNT_W-1:0]   cnt_sat;
	logic [WORD_W-1:0]  walk_count;
	logic [WORD_W-1:0]  walk_start;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign rsp_fire  = rsp_valid_q && rsp.ready;
	assign slot_ext  = SLOT_EXT_W'(req.payload.slot);

	assign rsp.valid                = rsp_valid_q;
	assign rsp.payload.node_sector  = rsp_sector_q;
	assign rsp.payload.sector_count = rsp_cnt_q;
	assign rsp.payload.status       = rsp_status_q;

	// one restoring divide step: shift in next dividend bit, subtract if it fits
	assign div_shift  = {div_rem_q, div_num_q[DIV_W-1]};
	assign div_diff   = div_shift - {1'b0, div_den_q};
	assign div_ge     = (div_shift >= {1'b0, div_den_q});
	assign div_rem_nx = div_ge ? div_diff[BLOCK_W-1:0] : div_shift[BLOCK_W-1:0];
	assign div_num_nx = {div_num_q[DIV_W-2:0], div_ge};
	assign div_last   = (div_step_q == '0);

	// sectors per node, clipped to the field
	assign cnt_quot = div_num_nx[NODE_SIZE_W-1:0];
	assign cnt_sat  = (cnt_quot > NODE_SIZE_W'(CNT_MAX)) ? CNT_MAX : cnt_quot[CNT_W-1:0];

	assign walk_count = ext_count_q[walk_k_q];
	assign walk_start = ext_start_q[walk_k_q];

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_size_q    <= NODE_SIZE_W'(4096);
			block_size_q   <= BLOCK_W'(4096);
			sector_size_q  <= SECTOR_W'(512);
			first_sector_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NODE_SIZE:    node_size_q    <= cfg_data[NODE_SIZE_W-1:0];
				CFG_BLOCK_SIZE:   block_size_q   <= cfg_data[BLOCK_W-1:0];
				CFG_SECTOR_SIZE:  sector_size_q  <= cfg_data[SECTOR_W-1:0];
				CFG_FIRST_SECTOR: first_sector_q <= cfg_data[WORD_W-1:0];
				default: ;
			endcase
		end
	end

	// extent table: slot writes, out-of-range slots dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < EXTENT_SLOTS; i++) begin
				ext_start_q[i] <= '0;
				ext_count_q[i] <= '0;
			end
		end else if (req_fire && req.payload.mode == MODE_WRITE &&
				slot_ext < SLOT_EXT_W'(EXTENT_SLOTS)) begin
			ext_start_q[slot_ext[IDX_W-1:0]] <= req.payload.extent_first_block;
			ext_count_q[slot_ext[IDX_W-1:0]] <= req.payload.extent_length;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			err_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire && req.payload.mode == MODE_TRANSLATE) begin
						if (block_size_q == '0 || sector_size_q == '0) begin
							err_q   <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							err_q   <= 1'b0;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL:     state_q <= ST_DIV_BLK;
				ST_DIV_BLK: if (div_last) state_q <= ST_DIV_PER;
				ST_DIV_PER: if (div_last) state_q <= ST_DIV_OFF;
				ST_DIV_OFF: if (div_last) state_q <= ST_DIV_CNT;
				ST_DIV_CNT: if (div_last) state_q <= ST_WALK;
				ST_WALK: begin
					if (walk_count == '0) begin
						err_q   <= 1'b1;
						state_q <= ST_DONE;
					end else if (remaining_q < walk_count) begin
						state_q <= ST_MUL2;
					end else if (walk_k_q == LAST_SLOT) begin
						err_q   <= 1'b1;
						state_q <= ST_DONE;
					end
				end
				ST_MUL2: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_DONE;
				ST_DONE: if (!rsp_valid_q || rsp.ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath: operand loads for the shared divider, walk and final sum
	always_ff @(posedge clk) begin
		case (state_q) inside
			ST_IDLE: node_q <= req.payload.node_idx;
			ST_MUL: begin
				div_num_q  <= {(DIV_W-WORD_W)'(0), node_q} * node_size_q;
				div_den_q  <= block_size_q;
				div_rem_q  <= '0;
				div_step_q <= STEP_W'(DIV_W - 1);
			end
			ST_DIV_BLK, ST_DIV_PER, ST_DIV_OFF, ST_DIV_CNT: begin
				if (div_last) begin
					div_rem_q <= '0;
					div_den_q <= BLOCK_W'(sector_size_q);
					case (state_q)
						ST_DIV_BLK: begin
							remaining_q <= div_num_nx[WORD_W-1:0];
							inblk_q     <= div_rem_nx;
							div_num_q   <= {block_size_q, (DIV_W-BLOCK_W)'(0)};
							div_step_q  <= STEP_W'(BLOCK_W - 1);
						end
						ST_DIV_PER: begin
							perblk_q   <= div_num_nx[BLOCK_W-1:0];
							div_num_q  <= {inblk_q, (DIV_W-BLOCK_W)'(0)};
							div_step_q <= STEP_W'(BLOCK_W - 1);
						end
						ST_DIV_OFF: begin
							base_q     <= {1'b0, first_sector_q} +
								(WORD_W+1)'(div_num_nx[BLOCK_W-1:0]);
							div_num_q  <= {node_size_q, (DIV_W-NODE_SIZE_W)'(0)};
							div_step_q <= STEP_W'(NODE_SIZE_W - 1);
						end
						default: begin
							cnt_q    <= cnt_sat;
							walk_k_q <= '0;
						end
					endcase
				end else begin
					div_num_q  <= div_num_nx;
					div_rem_q  <= div_rem_nx;
					div_step_q <= div_step_q - STEP_W'(1);
				end
			end
			ST_WALK: begin
				blk_q       <= walk_start + remaining_q;
				remaining_q <= remaining_q - walk_count;
				walk_k_q    <= walk_k_q + IDX_W'(1);
			end
			ST_MUL2: prod2_q <= blk_q * perblk_q;
			ST_SUM:  sector_q <= SECT_OUT_W'(prod2_q) + SECT_OUT_W'(base_q);
			default: ;
		endcase
	end

	// output register; a new result loads only once the previous one is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!rsp_valid_q || rsp.ready)) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_fire) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!rsp_valid_q || rsp.ready)) begin
			rsp_sector_q <= err_q ? '0 : sector_q;
			rsp_cnt_q    <= err_q ? '0 : cnt_q;
			rsp_status_q <= err_q ? STATUS_UNMAPPED : STATUS_MAPPED;
		end
	end

	// checks
	`BNSM_ASSERT_NXT(a_xlate_leaves_idle, clk, arst_n,
		req_fire && req.payload.mode == MODE_TRANSLATE, state_q != ST_IDLE,
		"translate transaction did not start the sequencer")
	`BNSM_ASSERT_IMP(a_walk_in_range, clk, arst_n,
		state_q == ST_WALK, walk_k_q <= LAST_SLOT, "extent walk ran past the table")
	`BNSM_ASSERT_IMP(a_div_nonzero, clk, arst_n,
		state_q == ST_DIV_BLK || state_q == ST_DIV_PER || state_q == ST_DIV_OFF ||
		state_q == ST_DIV_CNT, div_den_q != '0, "divider running with zero divisor")
	`BNSM_ASSERT_IMP(a_err_zero_payload, clk, arst_n,
		rsp_valid_q && rsp_status_q == STATUS_UNMAPPED,
		rsp_sector_q == '0 && rsp_cnt_q == '0, "error result with nonzero payload")

endmodule
